@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/qbc_pkg.sv @@
package qbc_pkg;

  // Request fields, Q16.16 boundary values and a Q8.16 duration.
  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
    logic        [23:0] duration;
  } in_t;

  // Result fields, Q31.32 coefficients and a status code.
  typedef struct packed {
    logic signed [63:0] coef_0;
    logic signed [63:0] coef_1;
    logic signed [63:0] coef_2;
    logic signed [63:0] coef_3;
    logic signed [63:0] coef_4;
    logic signed [63:0] coef_5;
    logic        [1:0]  status;
  } out_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int NQ    = 3;    // divided coefficients a3, a4, a5
  localparam int PW    = 38;   // position term width
  localparam int VW    = 37;   // velocity term width
  localparam int CW    = 36;   // acceleration term width
  localparam int NUM_W = 88;   // signed numerator width
  localparam int MAG_W = 87;   // numerator magnitude width
  localparam int DW    = 120;  // widest denominator, T^5
  localparam int QW    = 66;   // quotient bits of twice the ratio
  localparam int RW    = 190;  // partial remainder width

  // Left shift of each numerator magnitude, already including the extra bit for rounding.
  localparam int SHIFT_Q [NQ] = '{32, 48, 64};

endpackage

@@ rtl/quintic_boundary_coefficients.sv @@
// Quintic boundary coefficient unit. Each request carries start and end position, velocity and
// acceleration (signed Q16.16) and a duration T (unsigned Q8.16); the result holds the six
// coefficients a0..a5 (signed Q31.32) of the quintic that meets those conditions, plus a status.
// a0, a1 and a2 are exact. a3, a4 and a5 are rounded to nearest with ties away from zero and
// clamped to the signed 64-bit range, which sets status to saturated. A zero duration returns all
// zero coefficients and the zero-duration status. The unit is fully pipelined: it takes one
// request per clock while the pipeline is not halted, and every request passes through 76
// register stages before its result is presented on the output. Most of that depth comes from
// the three restoring dividers, which settle one quotient bit per stage over 66 stages. In front
// of them sit seven stages that form the numerators and the powers T^3, T^4 and T^5 with 24-bit
// partial products, plus one divider entry stage; behind them come one stage that rounds, clamps
// and assembles the result, and the output register. A two-entry output buffer lets the pipeline
// keep moving while one result waits, so in_ready depends only on registered state; the pipeline
// halts only while a second result is parked behind a stalled output.
module quintic_boundary_coefficients
  import qbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Side information that rides along with every request.
  typedef struct packed {
    logic signed [31:0] sp;
    logic signed [31:0] sv;
    logic signed [31:0] sa;
    logic               zero;
    logic [NQ-1:0]      neg;
  } side_t;

  // One restoring divider lane.
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
    logic          ovf;
  } div_t;

  logic en;
  logic skid_v_r;
  logic out_valid_r;
  out_t out_data_r;
  out_t skid_r;

  // The whole pipeline advances together; it only halts when the skid entry is occupied.
  assign en       = !skid_v_r;
  assign in_ready = en;

  // Stage 1: boundary differences and the combined terms of each numerator, plus T^2.
  logic               s1_v_r;
  logic signed [PW-1:0] s1_p_r   [NQ];
  logic signed [VW-1:0] s1_vel_r [NQ];
  logic signed [CW-1:0] s1_acc_r [NQ];
  logic        [23:0] s1_t_r;
  logic        [47:0] s1_t2_r;
  side_t              s1_sd_r;

  logic signed [32:0]   dp;
  logic signed [PW-1:0] dpx;
  logic signed [VW-1:0] evx, svx;
  logic signed [CW-1:0] eax, sax;
  logic signed [PW-1:0] p_nxt   [NQ];
  logic signed [VW-1:0] vel_nxt [NQ];
  logic signed [CW-1:0] acc_nxt [NQ];
  side_t                sd1_nxt;

  always_comb begin
    dp  = 33'(in_data.end_pos) - 33'(in_data.start_pos);
    dpx = PW'(dp);
    evx = VW'(in_data.end_vel);
    svx = VW'(in_data.start_vel);
    eax = CW'(in_data.end_acc);
    sax = CW'(in_data.start_acc);
    p_nxt[0]   = dpx * PW'(10);
    p_nxt[1]   = -(dpx * PW'(15));
    p_nxt[2]   = dpx * PW'(6);
    vel_nxt[0] = -(evx * VW'(4) + svx * VW'(6));
    vel_nxt[1] = evx * VW'(7) + svx * VW'(8);
    vel_nxt[2] = -((evx + svx) * VW'(3));
    acc_nxt[0] = eax - sax * CW'(3);
    acc_nxt[1] = sax * CW'(3) - eax * CW'(2);
    acc_nxt[2] = eax - sax;
    sd1_nxt.sp   = in_data.start_pos;
    sd1_nxt.sv   = in_data.start_vel;
    sd1_nxt.sa   = in_data.start_acc;
    sd1_nxt.zero = (in_data.duration == 24'd0);
    sd1_nxt.neg  = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r   <= p_nxt;
      s1_vel_r <= vel_nxt;
      s1_acc_r <= acc_nxt;
      s1_t_r   <= in_data.duration;
      s1_t2_r  <= 48'(in_data.duration) * 48'(in_data.duration);
      s1_sd_r  <= sd1_nxt;
    end
  end

  // Stage 2: velocity times T, acceleration times the two halves of T^2, and T^3 partials.
  logic                  s2_v_r;
  logic signed [PW-1:0]  s2_p_r   [NQ];
  logic signed [VW+24:0] s2_vt_r  [NQ];
  logic signed [CW+24:0] s2_alo_r [NQ];
  logic signed [CW+24:0] s2_ahi_r [NQ];
  logic        [47:0]    s2_t3lo_r, s2_t3hi_r;
  logic        [23:0]    s2_t_r;
  side_t                 s2_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NQ; k++) begin
        s2_vt_r[k]  <= (VW+25)'(s1_vel_r[k]) * (VW+25)'($signed({1'b0, s1_t_r}));
        s2_alo_r[k] <= (CW+25)'(s1_acc_r[k]) * (CW+25)'($signed({1'b0, s1_t2_r[23:0]}));
        s2_ahi_r[k] <= (CW+25)'(s1_acc_r[k]) * (CW+25)'($signed({1'b0, s1_t2_r[47:24]}));
      end
      s2_p_r    <= s1_p_r;
      s2_t3lo_r <= 48'(s1_t2_r[23:0]) * 48'(s1_t_r);
      s2_t3hi_r <= 48'(s1_t2_r[47:24]) * 48'(s1_t_r);
      s2_t_r    <= s1_t_r;
      s2_sd_r   <= s1_sd_r;
    end
  end

  // Stage 3: the signed numerators and T^3.
  logic                   s3_v_r;
  logic signed [NUM_W-1:0] s3_num_r [NQ];
  logic        [71:0]     s3_t3_r;
  logic        [23:0]     s3_t_r;
  side_t                  s3_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NQ; k++) begin
        s3_num_r[k] <= (NUM_W'(s2_p_r[k]) <<< 33) + (NUM_W'(s2_vt_r[k]) <<< 17)
                     + NUM_W'(s2_alo_r[k]) + (NUM_W'(s2_ahi_r[k]) <<< 24);
      end
      s3_t3_r <= 72'(s2_t3lo_r) + (72'(s2_t3hi_r) << 24);
      s3_t_r  <= s2_t_r;
      s3_sd_r <= s2_sd_r;
    end
  end

  // Stage 4: sign and magnitude of each numerator, T^4 partials.
  logic              s4_v_r;
  logic [MAG_W-1:0]  s4_mag_r [NQ];
  logic [47:0]       s4_t4p_r [3];
  logic [71:0]       s4_t3_r;
  logic [23:0]       s4_t_r;
  side_t             s4_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NQ; k++) begin
        s4_mag_r[k]   <= MAG_W'(s3_num_r[k][NUM_W-1] ? -s3_num_r[k] : s3_num_r[k]);
        s4_sd_r.neg[k] <= s3_num_r[k][NUM_W-1];
      end
      for (int j = 0; j < 3; j++) begin
        s4_t4p_r[j] <= 48'(s3_t3_r[j*24 +: 24]) * 48'(s3_t_r);
      end
      s4_sd_r.sp   <= s3_sd_r.sp;
      s4_sd_r.sv   <= s3_sd_r.sv;
      s4_sd_r.sa   <= s3_sd_r.sa;
      s4_sd_r.zero <= s3_sd_r.zero;
      s4_t3_r      <= s3_t3_r;
      s4_t_r       <= s3_t_r;
    end
  end

  // Stage 5: T^4.
  logic              s5_v_r;
  logic [MAG_W-1:0]  s5_mag_r [NQ];
  logic [95:0]       s5_t4_r;
  logic [71:0]       s5_t3_r;
  logic [23:0]       s5_t_r;
  side_t             s5_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t4_r  <= 96'(s4_t4p_r[0]) + (96'(s4_t4p_r[1]) << 24) + (96'(s4_t4p_r[2]) << 48);
      s5_mag_r <= s4_mag_r;
      s5_t3_r  <= s4_t3_r;
      s5_t_r   <= s4_t_r;
      s5_sd_r  <= s4_sd_r;
    end
  end

  // Stage 6: T^5 partials.
  logic              s6_v_r;
  logic [MAG_W-1:0]  s6_mag_r [NQ];
  logic [47:0]       s6_t5p_r [4];
  logic [95:0]       s6_t4_r;
  logic [71:0]       s6_t3_r;
  side_t             s6_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s6_t5p_r[j] <= 48'(s5_t4_r[j*24 +: 24]) * 48'(s5_t_r);
      end
      s6_mag_r <= s5_mag_r;
      s6_t4_r  <= s5_t4_r;
      s6_t3_r  <= s5_t3_r;
      s6_sd_r  <= s5_sd_r;
    end
  end

  // Stage 7: T^5.
  logic              s7_v_r;
  logic [MAG_W-1:0]  s7_mag_r [NQ];
  logic [DW-1:0]     s7_t5_r;
  logic [95:0]       s7_t4_r;
  logic [71:0]       s7_t3_r;
  side_t             s7_sd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_t5_r  <= DW'(s6_t5p_r[0]) + (DW'(s6_t5p_r[1]) << 24)
                + (DW'(s6_t5p_r[2]) << 48) + (DW'(s6_t5p_r[3]) << 72);
      s7_mag_r <= s6_mag_r;
      s7_t4_r  <= s6_t4_r;
      s7_t3_r  <= s6_t3_r;
      s7_sd_r  <= s6_sd_r;
    end
  end

  // Divider entry: the dividend is twice the scaled magnitude, so the quotient carries one extra
  // bit for rounding. A quotient that cannot fit in QW bits is flagged as overflow right here.
  div_t  dv_r   [QW+1][NQ];
  side_t dsd_r  [QW+1];
  logic [QW:0] dv_v_r;

  div_t           dv0_nxt [NQ];
  logic [DW-1:0]  den_sel [NQ];

  always_comb begin
    den_sel[0] = DW'(s7_t3_r);
    den_sel[1] = DW'(s7_t4_r);
    den_sel[2] = s7_t5_r;
    for (int k = 0; k < NQ; k++) begin
      dv0_nxt[k].rem = RW'(s7_mag_r[k]) << SHIFT_Q[k];
      dv0_nxt[k].den = den_sel[k];
      dv0_nxt[k].quo = '0;
      dv0_nxt[k].ovf = (dv0_nxt[k].rem >= (RW'(den_sel[k]) << QW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]  <= dv0_nxt;
      dsd_r[0] <= s7_sd_r;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int BIT = QW - j;
    div_t div_nxt [NQ];

    always_comb begin
      logic [RW:0] trial;
      for (int k = 0; k < NQ; k++) begin
        trial = {1'b0, dv_r[j-1][k].rem} - ((RW+1)'(dv_r[j-1][k].den) << BIT);
        div_nxt[k] = dv_r[j-1][k];
        if (!trial[RW]) begin
          div_nxt[k].rem      = trial[RW-1:0];
          div_nxt[k].quo[BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j]  <= div_nxt;
        dsd_r[j] <= dsd_r[j-1];
      end
    end
  end

  // Final stage: round, clamp, restore the sign and assemble the result.
  logic fin_v_r;
  out_t fin_r;
  out_t fin_nxt;

  always_comb begin
    logic [QW:0]        rnd;
    logic [QW:0]        lim;
    logic               sat_k;
    logic               any_sat;
    logic [63:0]        m64;
    logic signed [63:0] cq [NQ];
    side_t              sd;
    any_sat = 1'b0;
    sd      = dsd_r[QW];
    for (int k = 0; k < NQ; k++) begin
      rnd   = ({1'b0, dv_r[QW][k].quo} + (QW+1)'(1)) >> 1;
      lim   = sd.neg[k] ? (QW+1)'(64'h8000_0000_0000_0000)
                        : (QW+1)'(64'h7FFF_FFFF_FFFF_FFFF);
      sat_k = dv_r[QW][k].ovf || (rnd > lim);
      m64   = sat_k ? lim[63:0] : rnd[63:0];
      cq[k] = sd.neg[k] ? -$signed(m64) : $signed(m64);
      any_sat = any_sat | sat_k;
    end
    if (sd.zero) begin
      fin_nxt        = '0;
      fin_nxt.status = ST_ZERO;
    end else begin
      fin_nxt.coef_0 = {{16{sd.sp[31]}}, sd.sp, 16'h0000};
      fin_nxt.coef_1 = {{16{sd.sv[31]}}, sd.sv, 16'h0000};
      fin_nxt.coef_2 = {{17{sd.sa[31]}}, sd.sa, 15'h0000};
      fin_nxt.coef_3 = cq[0];
      fin_nxt.coef_4 = cq[1];
      fin_nxt.coef_5 = cq[2];
      fin_nxt.status = any_sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // Valid bits for every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      dv_v_r  <= '0;
      fin_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      dv_v_r  <= {dv_v_r[QW-1:0], s7_v_r};
      fin_v_r <= dv_v_r[QW];
    end
  end

  // Output register with a skid entry behind it. A result leaving the pipeline goes straight to
  // the output when that is free, otherwise it parks in the skid entry and the pipeline halts.
  logic out_free;
  logic push;

  assign out_free = !out_valid_r || out_ready;
  assign push     = en && fin_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_v_r) begin
          out_valid_r <= 1'b1;
          skid_v_r    <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_v_r ? skid_r : fin_r;
    end
    if (!out_free && push) begin
      skid_r <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/qbc_checker.sv @@
`include "assert_macros.svh"

module qbc_checker
  import qbc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Requests accepted but not yet delivered.
  logic [7:0] cnt_r;
  logic       in_acc;
  logic       out_acc;
  logic       all_zero;
  logic       lsb_ok;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // A zero-duration result carries six zero coefficients.
  assign all_zero = (out_data.coef_0 == 64'd0) && (out_data.coef_1 == 64'd0)
                 && (out_data.coef_2 == 64'd0) && (out_data.coef_3 == 64'd0)
                 && (out_data.coef_4 == 64'd0) && (out_data.coef_5 == 64'd0);

  // The exact coefficients are scaled inputs, so their low bits are always clear.
  assign lsb_ok = (out_data.coef_0[15:0] == 16'd0) && (out_data.coef_1[15:0] == 16'd0)
               && (out_data.coef_2[14:0] == 15'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_r <= cnt_r + 8'd1;
    end else if (!in_acc && out_acc) begin
      cnt_r <= cnt_r - 8'd1;
    end
  end

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, cnt_r != 8'd0)
  `ASSERT_IMP(a_zero_dur, clk, rst_n, out_valid && out_data.status == ST_ZERO, all_zero)
  `ASSERT_IMP(a_exact_lsb, clk, rst_n, out_valid, lsb_ok)

endmodule

bind quintic_boundary_coefficients qbc_checker u_qbc_checker (.*);
